// ===== design/pdft_pkg.sv =====
// Shared types and constants of the point-dipole field tensor unit.
package pdft_pkg;

  localparam int FIELD_W = 32;
  localparam int NORM_W = 16;
  localparam int FRAC_NORM = 28;
  localparam int INV_W = 29;
  localparam logic [INV_W-1:0] INV_4PI_Q32 = 29'd341782638;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OMIT = 2'd1;
  localparam logic [1:0] STATUS_COINCIDENT = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] target_x;
    logic signed [FIELD_W-1:0] target_y;
    logic signed [FIELD_W-1:0] target_z;
    logic signed [FIELD_W-1:0] source_x;
    logic signed [FIELD_W-1:0] source_y;
    logic signed [FIELD_W-1:0] source_z;
    logic                      omit_self;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] t_xx;
    logic signed [FIELD_W-1:0] t_xy;
    logic signed [FIELD_W-1:0] t_xz;
    logic signed [FIELD_W-1:0] t_yy;
    logic signed [FIELD_W-1:0] t_yz;
    logic signed [FIELD_W-1:0] t_zz;
    logic [1:0]                status;
  } out_t;

endpackage

// ===== design/pdft_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
module pdft_div #(
  parameter int LANES = 1,
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int QUO_W = 33,
  parameter int SB_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]              den,
  input  logic [SB_W-1:0]               sb_in,
  output logic                          out_valid,
  output logic [LANES-1:0][QUO_W-1:0]   quo,
  output logic [SB_W-1:0]               sb_out
);

  // The quotient must fit in QUO_W bits, so the top numerator bits start below the divisor.
  logic                          vld [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]   rem [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]   nq  [QUO_W];
  logic [DEN_W-1:0]              dv  [QUO_W];
  logic [SB_W-1:0]               sb  [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic                        vld_in;
    logic [DEN_W-1:0]            den_in;
    logic [SB_W-1:0]             sb_stage;
    logic [LANES-1:0][DEN_W-1:0] rem_in, rem_next;
    logic [LANES-1:0][QUO_W-1:0] nq_in, nq_next;

    if (s == 0) begin : g_first
      always_comb begin
        vld_in = in_valid;
        den_in = den;
        sb_stage = sb_in;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DEN_W'(num[l] >> QUO_W);
          nq_in[l] = num[l][QUO_W-1:0];
        end
      end
    end else begin : g_next
      assign vld_in = vld[s-1];
      assign den_in = dv[s-1];
      assign sb_stage = sb[s-1];
      assign rem_in = rem[s-1];
      assign nq_in = nq[s-1];
    end

    // Numerator bits leave at the top of nq while quotient bits enter at the bottom.
    always_comb begin
      for (int l = 0; l < LANES; l++) begin : g_lane
        logic [DEN_W:0] cat;
        logic [DEN_W:0] dif;
        cat = {rem_in[l], nq_in[l][QUO_W-1]};
        dif = cat - {1'b0, den_in};
        if (cat >= {1'b0, den_in}) begin
          rem_next[l] = dif[DEN_W-1:0];
          nq_next[l] = {nq_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[l] = cat[DEN_W-1:0];
          nq_next[l] = {nq_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
      rem[s] <= rem_next;
      nq[s] <= nq_next;
      dv[s] <= den_in;
      sb[s] <= sb_stage;
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo = nq[QUO_W-1];
  assign sb_out = sb[QUO_W-1];

endmodule

// ===== design/pdft_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module pdft_sqrt #(
  parameter int IN_W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 3;

  logic              vld [OUT_W];
  logic [REM_W-1:0]  rem [OUT_W];
  logic [OUT_W-1:0]  rt  [OUT_W];
  logic [IN_W-1:0]   vr  [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in, rem_next, cat, trial;
    logic [OUT_W-1:0] rt_in, rt_next;
    logic [IN_W-1:0]  vr_in;

    if (s == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = '0;
      assign rt_in = '0;
      assign vr_in = radicand;
    end else begin : g_next
      assign vld_in = vld[s-1];
      assign rem_in = rem[s-1];
      assign rt_in = rt[s-1];
      assign vr_in = vr[s-1];
    end

    always_comb begin
      cat = {rem_in[REM_W-3:0], vr_in[IN_W-1:IN_W-2]};
      trial = REM_W'({rt_in, 2'b01});
      if (cat >= trial) begin
        rem_next = cat - trial;
        rt_next = {rt_in[OUT_W-2:0], 1'b1};
      end else begin
        rem_next = cat;
        rt_next = {rt_in[OUT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld_in;
      end
      rem[s] <= rem_next;
      rt[s] <= rt_next;
      vr[s] <= {vr_in[IN_W-3:0], 2'b00};
    end
  end

  assign out_valid = vld[OUT_W-1];
  assign root = rt[OUT_W-1];

endmodule

// ===== design/point_dipole_field_tensor_unit.sv =====
// Point-dipole field tensor unit: top level of the fixed-point pipeline.
//
// A request carries target and source positions in signed Q16.16 and a self-pair
// flag. It is taken at a rising edge with start high and busy low; busy never
// rises, so a new request may enter on every cycle. Each request yields exactly
// one result: the six unique tensor components in saturating Q16.16 and a status
// (ok, omitted self pair, coincident points).
// The result appears on result for one cycle, with done high, from the output
// register behind stage 13. Results leave in request order at one per
// cycle. The depth is set by the 32-stage divider bank for the normalized
// components and square root, then the 33-stage reciprocal divider in series.
// The receiver cannot hold results off, so there is no back pressure.
// Synchronous reset clears every valid bit in the pipeline; requests in flight
// are dropped and no result comes out for them.
module point_dipole_field_tensor_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pdft_pkg::in_t  request,
  output logic           busy,
  output logic           done,
  output pdft_pkg::out_t result
);

  import pdft_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int BL_W = $clog2(CW + 1);
  localparam int EXP_W = 8;
  localparam int SQ_W = 2 * NORM_W;
  localparam int D_W = SQ_W + 2;
  localparam int N_W = D_W + 1;
  localparam int CNUM_W = N_W + FRAC_NORM;
  localparam int CQ_W = 32;
  localparam int RAD_W = 64;
  localparam int ROOT_W = RAD_W / 2;
  localparam int P_W = (D_W - NORM_W) + ROOT_W;
  localparam int PBL_W = $clog2(P_W + 1);
  localparam int SP_W = 7;
  localparam int PN_W = 32;
  localparam int YNUM_W = 64;
  localparam int YQ_W = 33;
  localparam int ZP_W = YQ_W + INV_W;
  localparam int Z_W = ZP_W - 32;
  localparam int M_W = CQ_W + Z_W;
  localparam int T_W = 10;
  localparam int CSB_W = D_W + EXP_W + 2 + 6;
  localparam int YSB_W = 6 * CQ_W + 6 + T_W + 2;

  localparam int PI_IDX [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ_IDX [6] = '{0, 1, 2, 1, 2, 2};
  localparam logic [5:0] DIAG = 6'b101001;
  localparam logic signed [T_W-1:0] T_LIMIT = T_W'(64);
  localparam logic signed [T_W-1:0] T_ZERO = '0;

  assign busy = 1'b0;

  // Stage 1: coordinate differences as sign and magnitude.
  logic                     s1_vld, s1_omit;
  logic [2:0]               s1_neg, s1_neg_next;
  logic [2:0][CW-1:0]       s1_mag, s1_mag_next;
  logic [2:0][FIELD_W-1:0]  tgt, src;

  assign tgt = {request.target_z, request.target_y, request.target_x};
  assign src = {request.source_z, request.source_y, request.source_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin : g_axis
      logic [63:0] tw, sw;
      logic [CW-1:0] ct, cs;
      logic [CW:0] d, dn;
      tw = 64'(tgt[k]);
      sw = 64'(src[k]);
      ct = tw[CW-1:0];
      cs = sw[CW-1:0];
      d = {ct[CW-1], ct} - {cs[CW-1], cs};
      dn = '0 - d;
      s1_neg_next[k] = d[CW];
      s1_mag_next[k] = d[CW] ? dn[CW-1:0] : d[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
    s1_omit <= request.omit_self;
    s1_neg <= s1_neg_next;
    s1_mag <= s1_mag_next;
  end

  // Stage 2: largest magnitude, its bit length and the status of the request.
  logic                     s2_vld;
  logic [2:0]               s2_neg;
  logic [2:0][CW-1:0]       s2_mag;
  logic [EXP_W-1:0]         s2_e, s2_e_next;
  logic [1:0]               s2_stat, s2_stat_next;
  logic [CW-1:0]            mx;
  logic [BL_W-1:0]          bl;

  always_comb begin
    mx = s1_mag[0];
    if (s1_mag[1] > mx) begin
      mx = s1_mag[1];
    end
    if (s1_mag[2] > mx) begin
      mx = s1_mag[2];
    end
    bl = '0;
    for (int i = 0; i < CW; i++) begin
      if (mx[i]) begin
        bl = BL_W'(i + 1);
      end
    end
    s2_e_next = EXP_W'(bl) - EXP_W'(NORM_W);
    if (s1_omit) begin
      s2_stat_next = STATUS_OMIT;
    end else if (mx == '0) begin
      s2_stat_next = STATUS_COINCIDENT;
    end else begin
      s2_stat_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_neg <= s1_neg;
    s2_mag <= s1_mag;
    s2_e <= s2_e_next;
    s2_stat <= s2_stat_next;
  end

  // Stage 3: scale all three magnitudes so the largest has 16 bits.
  logic                      s3_vld;
  logic [2:0]                s3_neg;
  logic [2:0][NORM_W-1:0]    s3_m, s3_m_next;
  logic [EXP_W-1:0]          s3_e;
  logic [1:0]                s3_stat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin : g_norm
      logic [CW+NORM_W-1:0] sh;
      logic [EXP_W-1:0] ne;
      ne = '0 - s2_e;
      if (!s2_e[EXP_W-1] && s2_e != '0) begin
        sh = (CW + NORM_W)'(s2_mag[k]) >> s2_e;
      end else begin
        sh = (CW + NORM_W)'(s2_mag[k]) << ne;
      end
      s3_m_next[k] = sh[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_neg <= s2_neg;
    s3_m <= s3_m_next;
    s3_e <= s2_e;
    s3_stat <= s2_stat;
  end

  // Stage 4: the six pairwise products.
  logic                    s4_vld;
  logic [5:0][SQ_W-1:0]    s4_prod;
  logic [5:0]              s4_pneg;
  logic [EXP_W-1:0]        s4_e;
  logic [1:0]              s4_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    for (int k = 0; k < 6; k++) begin
      s4_prod[k] <= SQ_W'(s3_m[PI_IDX[k]]) * SQ_W'(s3_m[PJ_IDX[k]]);
      s4_pneg[k] <= s3_neg[PI_IDX[k]] ^ s3_neg[PJ_IDX[k]];
    end
    s4_e <= s3_e;
    s4_stat <= s3_stat;
  end

  // Stage 5: squared length of the normalized vector.
  logic                    s5_vld;
  logic [5:0][SQ_W-1:0]    s5_prod;
  logic [5:0]              s5_pneg;
  logic [D_W-1:0]          s5_d;
  logic [EXP_W-1:0]        s5_e;
  logic [1:0]              s5_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_d <= D_W'(s4_prod[0]) + D_W'(s4_prod[3]) + D_W'(s4_prod[5]);
    s5_prod <= s4_prod;
    s5_pneg <= s4_pneg;
    s5_e <= s4_e;
    s5_stat <= s4_stat;
  end

  // Stage 6: numerators 3 m_i m_j, less the squared length on the diagonal.
  logic                    s6_vld;
  logic [5:0][N_W-1:0]     s6_nm, s6_nm_next;
  logic [5:0]              s6_nneg, s6_nneg_next;
  logic [D_W-1:0]          s6_d;
  logic [EXP_W-1:0]        s6_e;
  logic [1:0]              s6_stat;

  always_comb begin
    for (int k = 0; k < 6; k++) begin : g_numer
      logic [D_W-1:0] three;
      logic [N_W:0] sv, svn;
      three = D_W'({s5_prod[k], 1'b0}) + D_W'(s5_prod[k]);
      sv = s5_pneg[k] ? ('0 - (N_W + 1)'(three)) : (N_W + 1)'(three);
      if (DIAG[k]) begin
        sv = sv - (N_W + 1)'(s5_d);
      end
      svn = '0 - sv;
      s6_nneg_next[k] = sv[N_W];
      s6_nm_next[k] = sv[N_W] ? svn[N_W-1:0] : sv[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_nm <= s6_nm_next;
    s6_nneg <= s6_nneg_next;
    s6_d <= s5_d;
    s6_e <= s5_e;
    s6_stat <= s5_stat;
  end

  // Stage 7: Q28 dividends with half the divisor added for rounding.
  logic                    s7_vld;
  logic [5:0][CNUM_W-1:0]  s7_num;
  logic [5:0]              s7_nneg;
  logic [D_W-1:0]          s7_d;
  logic [EXP_W-1:0]        s7_e;
  logic [1:0]              s7_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
    for (int k = 0; k < 6; k++) begin
      s7_num[k] <= {s6_nm[k], {FRAC_NORM{1'b0}}} + CNUM_W'(s6_d >> 1);
    end
    s7_nneg <= s6_nneg;
    s7_d <= s6_d;
    s7_e <= s6_e;
    s7_stat <= s6_stat;
  end

  // Component quotients and the root of the squared length run side by side.
  logic                    cdiv_vld, sqrt_vld;
  logic [5:0][CQ_W-1:0]    cdiv_q;
  logic [CSB_W-1:0]        cdiv_sb;
  logic [ROOT_W-1:0]       sqrt_root;
  logic [D_W-1:0]          c_d;
  logic [EXP_W-1:0]        c_e;
  logic [1:0]              c_stat;
  logic [5:0]              c_nneg;

  pdft_div #(
    .LANES (6),
    .NUM_W (CNUM_W),
    .DEN_W (D_W),
    .QUO_W (CQ_W),
    .SB_W  (CSB_W)
  ) u_cdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_vld),
    .num       (s7_num),
    .den       (s7_d),
    .sb_in     ({s7_d, s7_e, s7_stat, s7_nneg}),
    .out_valid (cdiv_vld),
    .quo       (cdiv_q),
    .sb_out    (cdiv_sb)
  );

  pdft_sqrt #(
    .IN_W (RAD_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_vld),
    .radicand  ({s7_d, {(RAD_W - D_W){1'b0}}}),
    .out_valid (sqrt_vld),
    .root      (sqrt_root)
  );

  assign {c_d, c_e, c_stat, c_nneg} = cdiv_sb;

  // Stage 8: cube of the length, (D >> 16) times the root.
  logic                    s8_vld;
  logic [P_W-1:0]          s8_p;
  logic [5:0][CQ_W-1:0]    s8_c;
  logic [5:0]              s8_nneg;
  logic [EXP_W-1:0]        s8_e;
  logic [1:0]              s8_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= cdiv_vld;
    end
    s8_p <= P_W'(c_d[D_W-1:NORM_W]) * P_W'(sqrt_root);
    s8_c <= cdiv_q;
    s8_nneg <= c_nneg;
    s8_e <= c_e;
    s8_stat <= c_stat;
  end

  // Stage 9: bring the cube to 32 bits and form the final shift count.
  logic                    s9_vld;
  logic [PN_W-1:0]         s9_pn, s9_pn_next;
  logic signed [T_W-1:0]   s9_t, s9_t_next;
  logic [5:0][CQ_W-1:0]    s9_c;
  logic [5:0]              s9_nneg;
  logic [1:0]              s9_stat;
  logic [PBL_W-1:0]        pbl;
  logic signed [SP_W-1:0]  sp, nsp;
  logic [P_W-1:0]          psh;
  logic signed [T_W-1:0]   te;

  always_comb begin
    pbl = '0;
    for (int i = 0; i < P_W; i++) begin
      if (s8_p[i]) begin
        pbl = PBL_W'(i + 1);
      end
    end
    sp = SP_W'(pbl) - SP_W'(PN_W);
    nsp = '0 - sp;
    if (!sp[SP_W-1]) begin
      psh = s8_p >> sp;
    end else begin
      psh = s8_p << nsp;
    end
    s9_pn_next = psh[PN_W-1:0];
    te = T_W'($signed(s8_e));
    s9_t_next = T_W'(FRAC_NORM) + T_W'(sp) + te + te + te;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else begin
      s9_vld <= s8_vld;
    end
    s9_pn <= s9_pn_next;
    s9_t <= s9_t_next;
    s9_c <= s8_c;
    s9_nneg <= s8_nneg;
    s9_stat <= s8_stat;
  end

  // Reciprocal of the cube: 2^63 divided by the 32-bit normalized value.
  logic                    ydiv_vld;
  logic [0:0][YQ_W-1:0]    ydiv_q;
  logic [YSB_W-1:0]        ydiv_sb;
  logic [5:0][CQ_W-1:0]    y_c;
  logic [5:0]              y_nneg;
  logic [T_W-1:0]          y_t;
  logic [1:0]              y_stat;

  pdft_div #(
    .LANES (1),
    .NUM_W (YNUM_W),
    .DEN_W (PN_W),
    .QUO_W (YQ_W),
    .SB_W  (YSB_W)
  ) u_ydiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s9_vld),
    .num       ({1'b1, {(YNUM_W - 1){1'b0}}}),
    .den       (s9_pn),
    .sb_in     ({s9_c, s9_nneg, s9_t, s9_stat}),
    .out_valid (ydiv_vld),
    .quo       (ydiv_q),
    .sb_out    (ydiv_sb)
  );

  assign {y_c, y_nneg, y_t, y_stat} = ydiv_sb;

  // Stage 10: fold in 1 / (4 pi).
  logic                    s10_vld;
  logic [Z_W-1:0]          s10_z;
  logic [ZP_W-1:0]         zprod;
  logic [5:0][CQ_W-1:0]    s10_c;
  logic [5:0]              s10_nneg;
  logic signed [T_W-1:0]   s10_t;
  logic [1:0]              s10_stat;

  assign zprod = ZP_W'(ydiv_q[0]) * ZP_W'(INV_4PI_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else begin
      s10_vld <= ydiv_vld;
    end
    s10_z <= zprod[ZP_W-1:32];
    s10_c <= y_c;
    s10_nneg <= y_nneg;
    s10_t <= $signed(y_t);
    s10_stat <= y_stat;
  end

  // Stage 11: component quotient times scale.
  logic                    s11_vld;
  logic [5:0][M_W-1:0]     s11_m;
  logic [5:0]              s11_nneg;
  logic signed [T_W-1:0]   s11_t;
  logic [1:0]              s11_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
    end else begin
      s11_vld <= s10_vld;
    end
    for (int k = 0; k < 6; k++) begin
      s11_m[k] <= M_W'(s10_c[k]) * M_W'(s10_z);
    end
    s11_nneg <= s10_nneg;
    s11_t <= s10_t;
    s11_stat <= s10_stat;
  end

  // Stage 12: rounding right shift, zero when the count reaches 64, or a left shift when the count is not positive.
  logic                    s12_vld;
  logic [5:0][63:0]        s12_r, s12_r_next;
  logic [5:0]              s12_nneg;
  logic [1:0]              s12_stat;
  logic [T_W-1:0]          tneg;
  logic [5:0]              tpos_m1;

  always_comb begin
    tneg = '0 - s11_t;
    tpos_m1 = s11_t[5:0] - 6'd1;
    for (int k = 0; k < 6; k++) begin : g_round
      logic [63:0] mw;
      mw = 64'(s11_m[k]);
      if (s11_t >= T_LIMIT) begin
        s12_r_next[k] = '0;
      end else if (s11_t > T_ZERO) begin
        s12_r_next[k] = (mw + (64'd1 << tpos_m1)) >> s11_t[5:0];
      end else begin
        s12_r_next[k] = mw << tneg[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_vld <= 1'b0;
    end else begin
      s12_vld <= s11_vld;
    end
    s12_r <= s12_r_next;
    s12_nneg <= s11_nneg;
    s12_stat <= s11_stat;
  end

  // Stage 13: saturate, apply sign, and zero the tensor for the special cases.
  logic [5:0][FIELD_W-1:0] comp;

  always_comb begin
    for (int k = 0; k < 6; k++) begin : g_sat
      logic [FIELD_W-1:0] lo;
      lo = s12_r[k][FIELD_W-1:0];
      if (s12_stat != STATUS_OK) begin
        comp[k] = '0;
      end else if (s12_nneg[k]) begin
        comp[k] = (s12_r[k] > 64'h8000_0000) ? 32'h8000_0000 : ('0 - lo);
      end else begin
        comp[k] = (s12_r[k] > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s12_vld;
    end
    result.t_xx <= comp[0];
    result.t_xy <= comp[1];
    result.t_xz <= comp[2];
    result.t_yy <= comp[3];
    result.t_yz <= comp[4];
    result.t_zz <= comp[5];
    result.status <= s12_stat;
  end

  a_root_aligned: assert property (@(posedge clk) disable iff (rst)
    sqrt_vld == cdiv_vld)
    else $error("square root and component quotients out of step");

  a_recip_latency: assert property (@(posedge clk) disable iff (rst)
    ydiv_vld |-> $past(s9_vld, YQ_W))
    else $error("reciprocal result without a request entering the divider");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |->
      result.t_xx == '0 && result.t_xy == '0 && result.t_xz == '0 &&
      result.t_yy == '0 && result.t_yz == '0 && result.t_zz == '0)
    else $error("nonzero tensor on an omitted or coincident request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status == STATUS_OK || result.status == STATUS_OMIT ||
             result.status == STATUS_COINCIDENT)
    else $error("undefined status code on a result");

endmodule

// ===== verif/point_dipole_field_tensor_unit_test.sv =====
// Self-checking testbench of the point-dipole field tensor unit.
module point_dipole_field_tensor_unit_test;
  import pdft_pkg::*;

  localparam int CW = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1150;
  localparam int TAIL_CYCLES = 100;

  // Holds predicted tensors in request order and compares them with results.
  class tensor_scoreboard;
    out_t pending_tensors[$];
    int fail_count;

    function longint coord_value(logic [FIELD_W-1:0] v);
      logic [63:0] x;
      x = 64'(v) & ((64'd1 << CW) - 64'd1);
      if (x[CW-1]) return longint'(x) - longint'(64'd1 << CW);
      return longint'(x);
    endfunction

    function int bit_len(logic [63:0] v);
      int n;
      n = 0;
      while (v != 0) begin
        n++;
        v = v >> 1;
      end
      return n;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function out_t tensor_of(in_t rq);
      out_t o;
      logic [63:0] mag[3];
      bit neg[3];
      logic [63:0] mx, dsum, root, p, pn, y, z, nm, c, m, r, v;
      longint d, prod, n;
      int e, sp, t, i, j, k;
      int ii[6];
      int jj[6];
      ii = '{0, 0, 0, 1, 1, 2};
      jj = '{0, 1, 2, 1, 2, 2};
      o = '0;
      if (rq.omit_self) begin
        o.status = STATUS_OMIT;
        return o;
      end
      mx = 0;
      for (k = 0; k < 3; k++) begin
        case (k)
          0: d = coord_value(rq.target_x) - coord_value(rq.source_x);
          1: d = coord_value(rq.target_y) - coord_value(rq.source_y);
          default: d = coord_value(rq.target_z) - coord_value(rq.source_z);
        endcase
        neg[k] = d < 0;
        mag[k] = neg[k] ? 64'(-d) : 64'(d);
        if (mag[k] > mx) mx = mag[k];
      end
      if (mx == 0) begin
        o.status = STATUS_COINCIDENT;
        return o;
      end
      e = bit_len(mx) - NORM_W;
      for (k = 0; k < 3; k++) mag[k] = (e > 0) ? (mag[k] >> e) : (mag[k] << (-e));
      dsum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      root = int_sqrt(dsum << 30);
      p = (dsum >> 16) * root;
      sp = bit_len(p) - 32;
      pn = (sp > 0) ? (p >> sp) : (p << (-sp));
      y = (64'd1 << 63) / pn;
      z = (y * 64'(INV_4PI_Q32)) >> 32;
      t = FRAC_NORM + sp + 3 * e;
      for (k = 0; k < 6; k++) begin
        i = ii[k];
        j = jj[k];
        prod = longint'(mag[i] * mag[j]);
        if (neg[i] != neg[j]) prod = -prod;
        n = 3 * prod;
        if (i == j) n = n - longint'(dsum);
        nm = (n < 0) ? 64'(-n) : 64'(n);
        c = ((nm << FRAC_NORM) + (dsum >> 1)) / dsum;
        m = c * z;
        if (t >= 64) r = 0;
        else if (t > 0) r = (m + (64'd1 << (t - 1))) >> t;
        else r = m << (-t);
        if (n < 0) begin
          if (r > 64'h8000_0000) r = 64'h8000_0000;
          v = (64'd0 - r) & 64'hFFFF_FFFF;
        end else begin
          if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
          v = r;
        end
        case (k)
          0: o.t_xx = v[31:0];
          1: o.t_xy = v[31:0];
          2: o.t_xz = v[31:0];
          3: o.t_yy = v[31:0];
          4: o.t_yz = v[31:0];
          default: o.t_zz = v[31:0];
        endcase
      end
      o.status = STATUS_OK;
      return o;
    endfunction

    function void note_request(in_t rq);
      pending_tensors.push_back(tensor_of(rq));
    endfunction

    function void check_result(out_t got);
      out_t exp_t;
      if (pending_tensors.size() == 0) begin
        $error("result with no pending request");
        fail_count++;
        return;
      end
      exp_t = pending_tensors.pop_front();
      if (got.t_xx !== exp_t.t_xx) begin
        $error("t_xx expected %h actual %h", exp_t.t_xx, got.t_xx); fail_count++;
      end
      if (got.t_xy !== exp_t.t_xy) begin
        $error("t_xy expected %h actual %h", exp_t.t_xy, got.t_xy); fail_count++;
      end
      if (got.t_xz !== exp_t.t_xz) begin
        $error("t_xz expected %h actual %h", exp_t.t_xz, got.t_xz); fail_count++;
      end
      if (got.t_yy !== exp_t.t_yy) begin
        $error("t_yy expected %h actual %h", exp_t.t_yy, got.t_yy); fail_count++;
      end
      if (got.t_yz !== exp_t.t_yz) begin
        $error("t_yz expected %h actual %h", exp_t.t_yz, got.t_yz); fail_count++;
      end
      if (got.t_zz !== exp_t.t_zz) begin
        $error("t_zz expected %h actual %h", exp_t.t_zz, got.t_zz); fail_count++;
      end
      if (got.status !== exp_t.status) begin
        $error("status expected %0d actual %0d", exp_t.status, got.status); fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  in_t request;
  logic busy;
  logic done;
  out_t result;
  tensor_scoreboard board;
  int idle_cycles;

  point_dipole_field_tensor_unit #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) board.note_request(request);
      if (done) board.check_result(result);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1023)) - 512);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return 32'($signed($urandom_range(0, 8)) - 4) <<< $urandom_range(0, 28);
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // Drives one request and holds it until the block takes it.
  task automatic send_request(in_t rq, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pair(logic [31:0] tx, ty, tz, sx, sy, sz, bit om);
    in_t rq;
    rq.target_x = tx; rq.target_y = ty; rq.target_z = tz;
    rq.source_x = sx; rq.source_y = sy; rq.source_z = sz;
    rq.omit_self = om;
    send_request(rq, 1'b0);
  endtask

  initial begin
    in_t rq;
    int wait_cycles;
    board = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: self pair, coincident points, axes, extremes, diagonal.
    send_pair(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 1'b1);
    send_pair(32'h0001_0000, 2, 3, 0, 0, 0, 1'b1);
    send_pair(32'h1234_5678, 5, 7, 32'h1234_5678, 5, 7, 1'b0);
    send_pair(0, 0, 0, 0, 0, 0, 1'b0);
    send_pair(32'h0001_0000, 0, 0, 0, 0, 0, 1'b0);
    send_pair(0, 32'h0001_0000, 0, 0, 0, 0, 1'b0);
    send_pair(0, 0, 32'hFFFF_0000, 0, 0, 0, 1'b0);
    send_pair(1, 0, 0, 0, 0, 0, 1'b0);
    send_pair(1, 1, 1, 0, 0, 0, 1'b0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1'b0);
    send_pair(32'h0000_4000, 32'h0000_4000, 0, 0, 0, 0, 1'b0);
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 1'b0);
    send_pair(3, -32'sd5, 7, -32'sd2, 4, 1, 1'b0);
    send_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 1, 1'b0);

    for (int n = 0; n < N_RANDOM; n++) begin
      rq.target_x = rand_coord(); rq.target_y = rand_coord(); rq.target_z = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
        rq.source_x = rq.target_x; rq.source_y = rq.target_y; rq.source_z = rq.target_z;
      end else begin
        rq.source_x = rand_coord(); rq.source_y = rand_coord(); rq.source_z = rand_coord();
      end
      rq.omit_self = ($urandom_range(0, 9) == 0);
      send_request(rq, n < N_RANDOM - 150);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (board.pending_tensors.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.fail_count == 0 && board.pending_tensors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
